// ===== src/rgs_pkg.sv =====
// Shared types, constants and step tables for the retract gear sequencer.
// Depends on nothing; every other file refers to it by scoped names.
package rgs_pkg;

  localparam int unsigned SERVO_CHANNELS = 4;
  localparam int unsigned TABLE_LEN      = 5;

  localparam int unsigned US_W       = 12;
  localparam int unsigned TICK_W     = 8;
  localparam int unsigned RATE_W     = 8;
  localparam int unsigned ELAPSED_W  = 13;
  localparam int unsigned STEP_IDX_W = 3;
  localparam int unsigned WIDTH_W    = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CH_IDX_W   = $clog2(SERVO_CHANNELS);

  // accepted pulse window
  localparam logic [WIDTH_W-1:0] VALID_MIN_US = WIDTH_W'(500);
  localparam logic [WIDTH_W-1:0] VALID_MAX_US = WIDTH_W'(2500);

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // reset values of the configuration registers
  localparam logic [US_W-1:0]   LOWER_THR_RST  = US_W'(1250);
  localparam logic [US_W-1:0]   UPPER_THR_RST  = US_W'(1750);
  localparam logic [RATE_W-1:0] DOOR_RATE_RST  = RATE_W'(1);
  localparam logic [RATE_W-1:0] GEAR_RATE_RST  = RATE_W'(20);

  // home positions, indexed by channel with the door at index 0 (last in the list)
  localparam logic [SERVO_CHANNELS-1:0][US_W-1:0] HOME_US =
    {US_W'(1000), US_W'(1000), US_W'(1000), US_W'(950)};

  // divide by ten through a reciprocal, exact for values below 4200
  localparam logic [12:0] TICK_RECIP = 13'd6554;
  localparam int unsigned TICK_SHIFT = 16;
  localparam logic [12:0] TICK_ROUND = 13'd5;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    GEAR_NONE  = 2'd0,
    GEAR_LOWER = 2'd1,
    GEAR_RAISE = 2'd2
  } gear_e;

  typedef enum logic [2:0] {
    CH_DOOR   = 3'd0,
    CH_LEFT   = 3'd1,
    CH_RMAIN  = 3'd2,
    CH_NOSE   = 3'd3,
    CH_LIGHTS = 3'd4
  } chan_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_THR  = 3'd0,
    REG_UPPER_THR  = 3'd1,
    REG_DOOR_RATE  = 3'd2,
    REG_LEFT_RATE  = 3'd3,
    REG_RIGHT_RATE = 3'd4,
    REG_NOSE_RATE  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [US_W-1:0]                      lower_thr;
    logic [US_W-1:0]                      upper_thr;
    logic [SERVO_CHANNELS-1:0][RATE_W-1:0] slew_rate;
  } cfg_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] offset;
    chan_e                chan;
    logic [US_W-1:0]      value;
  } step_t;

  typedef struct packed {
    logic [SERVO_CHANNELS-1:0][TICK_W-1:0] ticks;
    logic                                  lights_on;
    logic                                  pulses_enabled;
    logic                                  sequence_busy;
    logic                                  moving_up;
  } result_t;

  // fixed step tables, lower and raise
  function automatic step_t step_entry(input logic raise, input logic [STEP_IDX_W-1:0] idx);
    step_t s;
    s = '{offset: '1, chan: CH_LIGHTS, value: '0};
    if (raise) begin
      case (idx)
        3'd0: s = '{offset: 13'd0,    chan: CH_LEFT,   value: 12'd2000};
        3'd1: s = '{offset: 13'd10,   chan: CH_LIGHTS, value: 12'd0};
        3'd2: s = '{offset: 13'd1000, chan: CH_RMAIN,  value: 12'd2000};
        3'd3: s = '{offset: 13'd2000, chan: CH_NOSE,   value: 12'd2000};
        3'd4: s = '{offset: 13'd7000, chan: CH_DOOR,   value: 12'd2050};
        default: s = '{offset: '1, chan: CH_LIGHTS, value: '0};
      endcase
    end else begin
      case (idx)
        3'd0: s = '{offset: 13'd0,    chan: CH_DOOR,   value: 12'd950};
        3'd1: s = '{offset: 13'd1200, chan: CH_LEFT,   value: 12'd1000};
        3'd2: s = '{offset: 13'd2200, chan: CH_RMAIN,  value: 12'd1000};
        3'd3: s = '{offset: 13'd3200, chan: CH_NOSE,   value: 12'd1000};
        3'd4: s = '{offset: 13'd6000, chan: CH_LIGHTS, value: 12'd1};
        default: s = '{offset: '1, chan: CH_LIGHTS, value: '0};
      endcase
    end
    return s;
  endfunction

  // microseconds to rounded 10 us units, never zero
  function automatic logic [TICK_W-1:0] us_to_ticks(input logic [US_W-1:0] us);
    logic [12:0] x;
    logic [25:0] p;
    logic [TICK_W-1:0] t;
    x = {1'b0, us} + TICK_ROUND;
    p = x * TICK_RECIP;
    t = p[TICK_SHIFT +: TICK_W];
    if (t == '0) begin
      t = TICK_W'(1);
    end
    return t;
  endfunction

endpackage

// ===== src/rgs_req_if.sv =====
// Request channel: ticks and pulse samples into the sequencer.
// Depends on rgs_pkg for field widths.
interface rgs_req_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [rgs_pkg::WIDTH_W-1:0]      pulse_width_us;

  modport source (output valid, output cmd, output pulse_width_us, input ready);
  modport sink   (input valid, input cmd, input pulse_width_us, output ready);
endinterface

// ===== src/rgs_res_if.sv =====
// Result channel: servo pulse lengths and status out of the sequencer.
// Depends on rgs_pkg for field widths.
interface rgs_res_if;
  logic                        valid;
  logic                        ready;
  logic [rgs_pkg::TICK_W-1:0]  door_ticks;
  logic [rgs_pkg::TICK_W-1:0]  left_ticks;
  logic [rgs_pkg::TICK_W-1:0]  right_ticks;
  logic [rgs_pkg::TICK_W-1:0]  nose_ticks;
  logic                        lights_on;
  logic                        pulses_enabled;
  logic                        sequence_busy;
  logic                        moving_up;

  modport source (output valid, output door_ticks, output left_ticks, output right_ticks,
                  output nose_ticks, output lights_on, output pulses_enabled,
                  output sequence_busy, output moving_up, input ready);
  modport sink   (input valid, input door_ticks, input left_ticks, input right_ticks,
                  input nose_ticks, input lights_on, input pulses_enabled,
                  input sequence_busy, input moving_up, output ready);
endinterface

// ===== src/rgs_cfg_regs.sv =====
// Configuration registers: thresholds and per-servo slew rates.
// Depends on rgs_pkg.
module rgs_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rgs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rgs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output rgs_pkg::cfg_t                    cfg_o
);

  rgs_pkg::cfg_t cfg_q, cfg_d;

  // decode the register index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (rgs_pkg::cfg_reg_e'(cfg_idx_i))
        rgs_pkg::REG_LOWER_THR:  cfg_d.lower_thr = cfg_data_i[rgs_pkg::US_W-1:0];
        rgs_pkg::REG_UPPER_THR:  cfg_d.upper_thr = cfg_data_i[rgs_pkg::US_W-1:0];
        rgs_pkg::REG_DOOR_RATE:  cfg_d.slew_rate[0] = cfg_data_i[rgs_pkg::RATE_W-1:0];
        rgs_pkg::REG_LEFT_RATE:  cfg_d.slew_rate[1] = cfg_data_i[rgs_pkg::RATE_W-1:0];
        rgs_pkg::REG_RIGHT_RATE: cfg_d.slew_rate[2] = cfg_data_i[rgs_pkg::RATE_W-1:0];
        rgs_pkg::REG_NOSE_RATE:  cfg_d.slew_rate[3] = cfg_data_i[rgs_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower_thr    <= rgs_pkg::LOWER_THR_RST;
      cfg_q.upper_thr    <= rgs_pkg::UPPER_THR_RST;
      cfg_q.slew_rate[0] <= rgs_pkg::DOOR_RATE_RST;
      cfg_q.slew_rate[1] <= rgs_pkg::GEAR_RATE_RST;
      cfg_q.slew_rate[2] <= rgs_pkg::GEAR_RATE_RST;
      cfg_q.slew_rate[3] <= rgs_pkg::GEAR_RATE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/rgs_slew.sv =====
// One servo channel: rate-limited move toward target and pulse tick conversion.
// Depends on rgs_pkg.
module rgs_slew (
  input  logic [rgs_pkg::US_W-1:0]    cur_i,
  input  logic [rgs_pkg::US_W-1:0]    tgt_i,
  input  logic [rgs_pkg::RATE_W-1:0]  rate_i,
  input  logic                        tick_i,
  output logic [rgs_pkg::US_W-1:0]    cur_o,
  output logic [rgs_pkg::TICK_W-1:0]  ticks_o
);

  logic [rgs_pkg::US_W-1:0] step;
  logic [rgs_pkg::US_W-1:0] up_gap;
  logic [rgs_pkg::US_W-1:0] down_gap;

  // zero rate behaves as one
  always_comb begin
    step     = (rate_i == '0) ? rgs_pkg::US_W'(1) : {{(rgs_pkg::US_W-rgs_pkg::RATE_W){1'b0}}, rate_i};
    up_gap   = tgt_i - cur_i;
    down_gap = cur_i - tgt_i;
    cur_o    = cur_i;
    if (tick_i) begin
      if (cur_i < tgt_i) begin
        cur_o = cur_i + ((up_gap > step) ? step : up_gap);
      end else if (cur_i > tgt_i) begin
        cur_o = cur_i - ((down_gap > step) ? step : down_gap);
      end
    end
  end

  assign ticks_o = rgs_pkg::us_to_ticks(cur_o);

endmodule

// ===== src/rgs_core.sv =====
// Sequencer state: command decode, step tables, elapsed time and servo positions.
// Depends on rgs_pkg and rgs_slew.
module rgs_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rgs_pkg::cfg_t                 cfg_i,
  input  logic                          go_i,
  input  logic                          cmd_i,
  input  logic [rgs_pkg::WIDTH_W-1:0]   width_i,
  output rgs_pkg::result_t              result_o
);

  localparam int unsigned NCH = rgs_pkg::SERVO_CHANNELS;

  logic                                     baseline_q, baseline_d;
  rgs_pkg::gear_e                           latched_q, latched_d;
  logic                                     enable_q, enable_d;
  logic                                     active_q, active_d;
  logic                                     raise_q, raise_d;
  logic [rgs_pkg::STEP_IDX_W-1:0]           idx_q, idx_d;
  logic [rgs_pkg::ELAPSED_W-1:0]            elapsed_q, elapsed_d;
  logic [NCH-1:0][rgs_pkg::US_W-1:0]        target_q, target_d;
  logic [NCH-1:0][rgs_pkg::US_W-1:0]        current_q, current_d;
  logic                                     lights_q, lights_d;

  logic                                     tick;
  logic                                     width_ok;
  rgs_pkg::gear_e                           code;
  logic                                     run;
  rgs_pkg::step_t                           step;
  logic [NCH-1:0][rgs_pkg::TICK_W-1:0]      ticks;

  assign tick = go_i && (rgs_pkg::cmd_e'(cmd_i) == rgs_pkg::CMD_TICK);

  // one slew unit per servo
  for (genvar g = 0; g < NCH; g++) begin : g_slew
    rgs_slew u_slew (
      .cur_i   (current_q[g]),
      .tgt_i   (target_q[g]),
      .rate_i  (cfg_i.slew_rate[g]),
      .tick_i  (tick),
      .cur_o   (current_d[g]),
      .ticks_o (ticks[g])
    );
  end

  // pulse decode, lower test first
  always_comb begin
    width_ok = (width_i >= rgs_pkg::VALID_MIN_US) && (width_i <= rgs_pkg::VALID_MAX_US);
    if (width_i < rgs_pkg::WIDTH_W'(cfg_i.lower_thr)) begin
      code = rgs_pkg::GEAR_LOWER;
    end else if (width_i > rgs_pkg::WIDTH_W'(cfg_i.upper_thr)) begin
      code = rgs_pkg::GEAR_RAISE;
    end else begin
      code = rgs_pkg::GEAR_NONE;
    end
  end

  // next state: command latch, sequence start, time advance and one due step
  always_comb begin
    baseline_d = baseline_q;
    latched_d  = latched_q;
    enable_d   = enable_q;
    active_d   = active_q;
    raise_d    = raise_q;
    idx_d      = idx_q;
    elapsed_d  = elapsed_q;
    target_d   = target_q;
    lights_d   = lights_q;
    run        = 1'b0;

    if (tick) begin
      if (active_q) begin
        if (elapsed_q != rgs_pkg::ELAPSED_MAX) begin
          elapsed_d = elapsed_q + 1'b1;
        end
        run = 1'b1;
      end
    end else if (go_i && width_ok) begin
      if (!baseline_q) begin
        latched_d  = code;
        baseline_d = 1'b1;
      end else if (code == rgs_pkg::GEAR_NONE) begin
        latched_d = rgs_pkg::GEAR_NONE;
      end else if (code != latched_q) begin
        latched_d = code;
        enable_d  = 1'b1;
        raise_d   = (code == rgs_pkg::GEAR_RAISE);
        idx_d     = '0;
        elapsed_d = '0;
        active_d  = 1'b1;
        run       = 1'b1;
      end
    end

    // offsets are strictly rising, so at most one step falls due per item
    step = rgs_pkg::step_entry(raise_d, idx_d);
    if (run) begin
      if ((idx_d < rgs_pkg::STEP_IDX_W'(rgs_pkg::TABLE_LEN)) && (elapsed_d >= step.offset)) begin
        case (step.chan)
          rgs_pkg::CH_DOOR, rgs_pkg::CH_LEFT, rgs_pkg::CH_RMAIN, rgs_pkg::CH_NOSE:
            target_d[step.chan[rgs_pkg::CH_IDX_W-1:0]] = step.value;
          rgs_pkg::CH_LIGHTS: lights_d = (step.value != '0);
          default: ;
        endcase
        idx_d = idx_d + 1'b1;
      end
      if (idx_d >= rgs_pkg::STEP_IDX_W'(rgs_pkg::TABLE_LEN)) begin
        active_d = 1'b0;
      end
    end
  end

  // state registers, updated only when an item is processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= 1'b0;
      latched_q  <= rgs_pkg::GEAR_NONE;
      enable_q   <= 1'b0;
      active_q   <= 1'b0;
      raise_q    <= 1'b0;
      idx_q      <= '0;
      elapsed_q  <= '0;
      target_q   <= rgs_pkg::HOME_US;
      current_q  <= rgs_pkg::HOME_US;
      lights_q   <= 1'b0;
    end else if (go_i) begin
      baseline_q <= baseline_d;
      latched_q  <= latched_d;
      enable_q   <= enable_d;
      active_q   <= active_d;
      raise_q    <= raise_d;
      idx_q      <= idx_d;
      elapsed_q  <= elapsed_d;
      target_q   <= target_d;
      current_q  <= current_d;
      lights_q   <= lights_d;
    end
  end

  // result reflects the state after this item
  always_comb begin
    result_o.ticks          = ticks;
    result_o.lights_on      = lights_d;
    result_o.pulses_enabled = enable_d;
    result_o.sequence_busy  = active_d;
    result_o.moving_up      = raise_d;
  end

endmodule

// ===== src/retract_gear_sequencer.sv =====
// Top level of the retract gear sequencer: input register, core, result register.
// Depends on rgs_pkg, rgs_req_if, rgs_res_if, rgs_cfg_regs and rgs_core.
//
//   channel   dir   carries                                   handshake
//   req_i     in    cmd, pulse_width_us                       valid/ready
//   res_o     out   four servo ticks, lights, enable, busy,   valid/ready
//                   direction
//   cfg_*_i   in    register index and data                   write enable
//
// Each request is held in the input register, is processed by the core logic and
// lands in the result register.
// One request is taken per cycle while the result side keeps up; a stalled
// result holds the input register, which then holds off further requests.
// Reset puts the servos at home and clears all sequence state; no clearing pass.
module retract_gear_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rgs_req_if.sink                        req_i,
  rgs_res_if.source                      res_o
);

  rgs_pkg::cfg_t                 cfg;
  rgs_pkg::result_t              result;

  logic                          in_valid_q, in_valid_d;
  logic                          in_cmd_q;
  logic [rgs_pkg::WIDTH_W-1:0]   in_width_q;
  logic                          out_valid_q, out_valid_d;
  rgs_pkg::result_t              out_data_q;
  logic                          advance;
  logic                          req_take;

  rgs_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // item moves on when the result register is free or being emptied
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign req_take    = req_i.valid && req_i.ready;

  rgs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .go_i     (advance),
    .cmd_i    (in_cmd_q),
    .width_i  (in_width_q),
    .result_o (result)
  );

  // input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (req_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      in_cmd_q   <= req_i.cmd;
      in_width_q <= req_i.pulse_width_us;
    end
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.door_ticks     = out_data_q.ticks[0];
  assign res_o.left_ticks     = out_data_q.ticks[1];
  assign res_o.right_ticks    = out_data_q.ticks[2];
  assign res_o.nose_ticks     = out_data_q.ticks[3];
  assign res_o.lights_on      = out_data_q.lights_on;
  assign res_o.pulses_enabled = out_data_q.pulses_enabled;
  assign res_o.sequence_busy  = out_data_q.sequence_busy;
  assign res_o.moving_up      = out_data_q.moving_up;

endmodule
